// File: rtl/sflr_pkg.sv
// Shared types and constants for the sync/length frame receiver.
`default_nettype none

package sflr_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_BYTE   = 2'd0,
		ST_DONE   = 2'd1,
		ST_LENERR = 2'd2,
		ST_ABORT  = 2'd3
	} status_t;

	// Receiver phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_SECOND  = 5'b00010,
		PH_LEN_HI  = 5'b00100,
		PH_LEN_LO  = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// Configuration register indexes
	localparam logic [2:0] CFG_SYNC_FIRST    = 3'd0;
	localparam logic [2:0] CFG_SYNC_SECOND   = 3'd1;
	localparam logic [2:0] CFG_MIN_LENGTH    = 3'd2;
	localparam logic [2:0] CFG_MAX_LENGTH    = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd4;

	// Input mode codes
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [15:0] DEFAULT_TIMEOUT = 16'd500;
	localparam logic [16:0] HDR_BYTES       = 17'd4;

	localparam logic [7:0]  RST_SYNC_FIRST  = 8'd170;
	localparam logic [7:0]  RST_SYNC_SECOND = 8'd85;
	localparam logic [15:0] RST_MIN_LENGTH  = 16'd1;
	localparam logic [15:0] RST_MAX_LENGTH  = 16'd1024;
	localparam logic [15:0] RST_TIMEOUT     = 16'd500;

endpackage

`default_nettype wire

// File: rtl/sync_length_frame_receiver_top.sv
// Sync/length frame receiver: deframes UART bytes with a two-byte sync header.
//
// Input channel (in_valid / in_stall): one item per transfer, either a received
// byte (mode = 0, rx_byte) or one idle tick (mode = 1). Output channel
// (out_valid / out_stall): zero or one result per input item, with status,
// payload_byte, last and frame_length. Results come out in input order.
//
// The block hunts for sync_first then sync_second, reads a big-endian length,
// checks it against min_length / max_length and LENGTH_BITS, then passes the
// payload bytes out. The final byte has status "done", last = 1 and the frame
// length (payload + 4). A bad second sync byte (not a repeat of sync_first) or
// idle timeout in a frame gives "abort"; a bad length gives "length error".
// Bytes and ticks while hunting produce nothing.
//
// An input transfer reaches the output through the input register, then decode
// into the result register.
// Throughput: one item per cycle; the input register is refilled in the same
// cycle that its item moves on. When the receiver stalls and a result is held,
// an item needing a result waits in the input register and in_stall rises;
// items that give no result keep flowing.
// Reset (arst_n low) restores the register defaults, empties both registers and
// returns to hunting. Configuration writes (cfg_wr_en) take effect at once.
`default_nettype none

module sync_length_frame_receiver_top #(
	parameter int LENGTH_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  rx_byte,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       payload_byte,
	output logic             last,
	output logic [16:0]      frame_length
);

	// Configuration registers
	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [15:0] min_length_q;
	logic [15:0] max_length_q;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= sflr_pkg::RST_SYNC_FIRST;
			sync_second_q <= sflr_pkg::RST_SYNC_SECOND;
			min_length_q  <= sflr_pkg::RST_MIN_LENGTH;
			max_length_q  <= sflr_pkg::RST_MAX_LENGTH;
			timeout_q     <= sflr_pkg::RST_TIMEOUT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sflr_pkg::CFG_SYNC_FIRST:    sync_first_q  <= cfg_data[7:0];
				sflr_pkg::CFG_SYNC_SECOND:   sync_second_q <= cfg_data[7:0];
				sflr_pkg::CFG_MIN_LENGTH:    min_length_q  <= cfg_data;
				sflr_pkg::CFG_MAX_LENGTH:    max_length_q  <= cfg_data;
				sflr_pkg::CFG_TIMEOUT_TICKS: timeout_q     <= cfg_data;
				default: ; // unknown index: write dropped
			endcase
		end
	end

	// Input register
	logic       s1_valid;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       in_xfer;
	logic       s1_fire;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = s1_valid && !s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_xfer) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
	end

	// Frame state
	sflr_pkg::phase_t       phase_q, phase_d;
	logic [7:0]             len_hi_q, len_hi_d;
	logic [LENGTH_BITS-1:0] pay_len_q, pay_len_d;
	logic [LENGTH_BITS-1:0] left_q, left_d;
	logic [15:0]            idle_q, idle_d;

	// Decode results
	logic              res_valid;
	sflr_pkg::status_t res_status;
	logic [7:0]        res_byte;
	logic              res_last;
	logic [16:0]       res_flen;

	logic [15:0] limit;
	logic [15:0] idle_inc;
	logic [15:0] len_w;
	logic        len_bad;
	logic        out_free;

	assign limit    = (timeout_q == 16'd0) ? sflr_pkg::DEFAULT_TIMEOUT : timeout_q;
	assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;
	assign len_w    = {len_hi_q, byte_s1};
	assign len_bad  = (len_w == 16'd0) || (len_w < min_length_q) || (len_w > max_length_q)
		|| ((len_w >> LENGTH_BITS) != 16'd0);

	always_comb begin
		phase_d    = phase_q;
		len_hi_d   = len_hi_q;
		pay_len_d  = pay_len_q;
		left_d     = left_q;
		idle_d     = idle_q;
		res_valid  = 1'b0;
		res_status = sflr_pkg::ST_BYTE;
		res_byte   = 8'd0;
		res_last   = 1'b0;
		res_flen   = 17'd0;

		if (mode_s1 == sflr_pkg::MODE_TICK) begin
			if (phase_q != sflr_pkg::PH_HUNT) begin
				idle_d = idle_inc;
				if (idle_inc >= limit) begin
					phase_d    = sflr_pkg::PH_HUNT;
					len_hi_d   = 8'd0;
					pay_len_d  = '0;
					left_d     = '0;
					idle_d     = 16'd0;
					res_valid  = 1'b1;
					res_status = sflr_pkg::ST_ABORT;
				end
			end
		end else begin
			idle_d = 16'd0;
			unique case (phase_q)
				sflr_pkg::PH_HUNT: begin
					if (byte_s1 == sync_first_q) phase_d = sflr_pkg::PH_SECOND;
				end
				sflr_pkg::PH_SECOND: begin
					if (byte_s1 == sync_second_q) begin
						phase_d = sflr_pkg::PH_LEN_HI;
					end else if (byte_s1 != sync_first_q) begin
						phase_d    = sflr_pkg::PH_HUNT;
						len_hi_d   = 8'd0;
						pay_len_d  = '0;
						left_d     = '0;
						res_valid  = 1'b1;
						res_status = sflr_pkg::ST_ABORT;
					end
				end
				sflr_pkg::PH_LEN_HI: begin
					len_hi_d = byte_s1;
					phase_d  = sflr_pkg::PH_LEN_LO;
				end
				sflr_pkg::PH_LEN_LO: begin
					if (len_bad) begin
						phase_d    = sflr_pkg::PH_HUNT;
						len_hi_d   = 8'd0;
						pay_len_d  = '0;
						left_d     = '0;
						res_valid  = 1'b1;
						res_status = sflr_pkg::ST_LENERR;
					end else begin
						pay_len_d = len_w[LENGTH_BITS-1:0];
						left_d    = len_w[LENGTH_BITS-1:0];
						phase_d   = sflr_pkg::PH_PAYLOAD;
					end
				end
				sflr_pkg::PH_PAYLOAD: begin
					res_valid = 1'b1;
					res_byte  = byte_s1;
					if (left_q <= LENGTH_BITS'(1)) begin
						phase_d    = sflr_pkg::PH_HUNT;
						len_hi_d   = 8'd0;
						pay_len_d  = '0;
						left_d     = '0;
						res_status = sflr_pkg::ST_DONE;
						res_last   = 1'b1;
						res_flen   = 17'(pay_len_q) + sflr_pkg::HDR_BYTES;
					end else begin
						left_d     = left_q - LENGTH_BITS'(1);
						res_status = sflr_pkg::ST_BYTE;
					end
				end
				default: begin
					phase_d   = sflr_pkg::PH_HUNT;
					len_hi_d  = 8'd0;
					pay_len_d = '0;
					left_d    = '0;
				end
			endcase
		end
	end

	// The item in the input register moves on unless it needs the output register
	// and that register is held by a stalled result.
	assign out_free = !out_valid || !out_stall;
	assign s1_fire  = s1_valid && (!res_valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sflr_pkg::PH_HUNT;
			len_hi_q  <= 8'd0;
			pay_len_q <= '0;
			left_q    <= '0;
			idle_q    <= 16'd0;
		end else if (s1_fire) begin
			phase_q   <= phase_d;
			len_hi_q  <= len_hi_d;
			pay_len_q <= pay_len_d;
			left_q    <= left_d;
			idle_q    <= idle_d;
		end
	end

	// Result register
	logic              out_valid_q;
	sflr_pkg::status_t status_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic [16:0]       flen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			status_q <= res_status;
			byte_q   <= res_byte;
			last_q   <= res_last;
			flen_q   <= res_flen;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign payload_byte = byte_q;
	assign last         = last_q;
	assign frame_length = flen_q;

	// Checks
	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid)
		else $error("in_stall raised with empty input register");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && res_valid) |=> out_valid)
		else $error("result lost on its way to the output register");

	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (status == sflr_pkg::ST_DONE)))
		else $error("last flag and done status disagree");

	a_flen_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != sflr_pkg::ST_DONE) |-> (frame_length == 17'd0))
		else $error("frame length set on a result that is not done");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sflr_pkg::PH_PAYLOAD) |-> (left_q != '0 && left_q <= pay_len_q))
		else $error("payload byte counter out of range");

endmodule

`default_nettype wire
